/* design/i2cm_pkg.sv */
// i2cm_pkg: shared types, section codes and sequence plan tables for the
// single-register I2C master. No dependencies.
package i2cm_pkg;

    localparam int PHASE_TICKS_W   = 16;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] IDLE_STEP = 6'd63;

    // section codes
    localparam logic [2:0] SEC_END   = 3'd0;
    localparam logic [2:0] SEC_START = 3'd1;
    localparam logic [2:0] SEC_SEND  = 3'd2;
    localparam logic [2:0] SEC_ACK   = 3'd3;
    localparam logic [2:0] SEC_RECV  = 3'd4;
    localparam logic [2:0] SEC_NOACK = 3'd5;
    localparam logic [2:0] SEC_STOP  = 3'd6;

    // byte sources for a send section
    localparam logic [1:0] SRC_DEVICE   = 2'd0;
    localparam logic [1:0] SRC_REGISTER = 2'd1;
    localparam logic [1:0] SRC_DATA     = 2'd2;
    localparam logic [1:0] SRC_DEV_READ = 2'd3;

    // transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [2:0] sec;
        logic [1:0] arg;
    } plan_entry_t;

    typedef struct packed {
        logic       request_valid;
        logic       kind;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       write_aborted;
        logic       start_fault;
        logic [2:0] nack_flags;
        logic [7:0] read_data;
    } result_t;

    function automatic plan_entry_t plan_lookup(input logic rd, input logic [3:0] idx);
        plan_entry_t e;
        e = '{sec: SEC_END, arg: 2'd0};
        if (rd == KIND_READ) begin
            unique case (idx)
                4'd0:    e = '{sec: SEC_START, arg: 2'd0};
                4'd1:    e = '{sec: SEC_SEND,  arg: SRC_DEVICE};
                4'd2:    e = '{sec: SEC_ACK,   arg: 2'd0};
                4'd3:    e = '{sec: SEC_SEND,  arg: SRC_REGISTER};
                4'd4:    e = '{sec: SEC_ACK,   arg: 2'd1};
                4'd5:    e = '{sec: SEC_START, arg: 2'd0};
                4'd6:    e = '{sec: SEC_SEND,  arg: SRC_DEV_READ};
                4'd7:    e = '{sec: SEC_ACK,   arg: 2'd2};
                4'd8:    e = '{sec: SEC_RECV,  arg: 2'd0};
                4'd9:    e = '{sec: SEC_NOACK, arg: 2'd0};
                4'd10:   e = '{sec: SEC_STOP,  arg: 2'd0};
                default: e = '{sec: SEC_END,   arg: 2'd0};
            endcase
        end else begin
            unique case (idx)
                4'd0:    e = '{sec: SEC_START, arg: 2'd0};
                4'd1:    e = '{sec: SEC_SEND,  arg: SRC_DEVICE};
                4'd2:    e = '{sec: SEC_ACK,   arg: 2'd0};
                4'd3:    e = '{sec: SEC_SEND,  arg: SRC_REGISTER};
                4'd4:    e = '{sec: SEC_ACK,   arg: 2'd1};
                4'd5:    e = '{sec: SEC_SEND,  arg: SRC_DATA};
                4'd6:    e = '{sec: SEC_ACK,   arg: 2'd2};
                4'd7:    e = '{sec: SEC_STOP,  arg: 2'd0};
                default: e = '{sec: SEC_END,   arg: 2'd0};
            endcase
        end
        return e;
    endfunction

endpackage

/* design/i2cm_seq.sv */
// i2cm_seq: bus sequencer state and the one-tick step logic.
// Depends on i2cm_pkg.
module i2cm_seq #(
    parameter int TIMER_W = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [i2cm_pkg::PHASE_TICKS_W-1:0] phase_ticks,
    input  logic                              step_en,
    input  i2cm_pkg::in_item_t                item,
    output i2cm_pkg::result_t                 result
);

    localparam int CW = ((TIMER_W > i2cm_pkg::PHASE_TICKS_W) ?
                         TIMER_W : i2cm_pkg::PHASE_TICKS_W) + 1;

    logic [i2cm_pkg::STEP_W-1:0] step_reg, step_next;
    logic [TIMER_W-1:0]          timer_reg, timer_next;
    logic [3:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    logic                        kind_reg;
    logic [7:0]                  dev_reg, regaddr_reg, wdata_reg;
    logic [2:0]                  nack_reg, nack_next;
    logic                        fault_reg, fault_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;

    logic                        idle, active;
    logic                        eff_kind;
    logic [7:0]                  eff_dev, eff_regaddr, eff_wdata;
    logic [i2cm_pkg::STEP_W-1:0] eff_step;
    logic [TIMER_W-1:0]          eff_timer;
    logic [3:0]                  eff_bit;
    logic [7:0]                  eff_shift;
    logic [2:0]                  eff_nack;
    logic                        eff_fault;
    i2cm_pkg::plan_entry_t       entry, nxt_entry;
    logic [1:0]                  sub;
    logic [4:0]                  nxt;
    logic [CW-1:0]               lim, pt_ext, cap, count_ext;
    logic                        expire, go_next, finished, aborted, fail;

    assign pt_ext = CW'(phase_ticks);
    assign cap    = CW'(1) << TIMER_W;

    always_comb begin
        if (pt_ext == '0) begin
            lim = CW'(1);
        end else if (pt_ext > cap) begin
            lim = cap;
        end else begin
            lim = pt_ext;
        end
    end

    always_comb begin
        idle   = (step_reg == i2cm_pkg::IDLE_STEP);
        active = !idle || item.request_valid;

        // a fresh request loads the held bytes and clears the run state
        if (idle) begin
            eff_kind    = item.kind;
            eff_dev     = item.device_address;
            eff_regaddr = item.register_address;
            eff_wdata   = item.write_data;
            eff_step    = '0;
            eff_timer   = '0;
            eff_bit     = '0;
            eff_shift   = '0;
            eff_nack    = '0;
            eff_fault   = 1'b0;
        end else begin
            eff_kind    = kind_reg;
            eff_dev     = dev_reg;
            eff_regaddr = regaddr_reg;
            eff_wdata   = wdata_reg;
            eff_step    = step_reg;
            eff_timer   = timer_reg;
            eff_bit     = bit_reg;
            eff_shift   = shift_reg;
            eff_nack    = nack_reg;
            eff_fault   = fault_reg;
        end

        entry = i2cm_pkg::plan_lookup(eff_kind, eff_step[5:2]);
        sub   = eff_step[1:0];

        // line changes on the first tick of a step
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = eff_shift;
        if (eff_timer == '0) begin
            case (entry.sec)
                i2cm_pkg::SEC_START: begin
                    if (sub == 2'd0) begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end else begin
                        sda_next = 1'b0;
                    end
                end
                i2cm_pkg::SEC_SEND: begin
                    if (sub == 2'd0) begin
                        scl_next = 1'b0;
                    end else if (sub == 2'd1) begin
                        sda_next   = eff_shift[7];
                        shift_next = {eff_shift[6:0], 1'b0};
                    end else begin
                        scl_next = 1'b1;
                    end
                end
                i2cm_pkg::SEC_ACK, i2cm_pkg::SEC_NOACK: begin
                    if (sub == 2'd1) begin
                        sda_next = 1'b1;
                    end else begin
                        scl_next = (sub == 2'd2);
                    end
                end
                i2cm_pkg::SEC_RECV: begin
                    scl_next = (sub != 2'd0);
                end
                i2cm_pkg::SEC_STOP: begin
                    case (sub)
                        2'd0:    scl_next = 1'b0;
                        2'd1:    sda_next = 1'b0;
                        2'd2:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                default: ;
            endcase
        end

        count_ext = CW'(eff_timer) + CW'(1);
        expire    = (count_ext >= lim);

        step_next  = eff_step;
        timer_next = eff_timer + TIMER_W'(1);
        bit_next   = eff_bit;
        nack_next  = eff_nack;
        fault_next = eff_fault;
        finished   = 1'b0;
        aborted    = 1'b0;
        go_next    = 1'b0;
        fail       = ((sub == 2'd0) && !item.sda_in) || ((sub == 2'd1) && item.sda_in);

        if (expire) begin
            timer_next = '0;
            case (entry.sec)
                i2cm_pkg::SEC_START: begin
                    if (fail) begin
                        fault_next = 1'b1;
                        if (eff_kind == i2cm_pkg::KIND_WRITE) begin
                            // abort: leave the lines, no stop
                            step_next = i2cm_pkg::IDLE_STEP;
                            finished  = 1'b1;
                            aborted   = 1'b1;
                        end else begin
                            go_next = 1'b1;
                        end
                    end else if (sub >= 2'd2) begin
                        go_next = 1'b1;
                    end else begin
                        step_next = {eff_step[5:2], sub + 2'd1};
                    end
                end
                i2cm_pkg::SEC_SEND: begin
                    if (sub < 2'd2) begin
                        step_next = {eff_step[5:2], sub + 2'd1};
                    end else begin
                        bit_next = eff_bit + 4'd1;
                        if (bit_next >= 4'd8) begin
                            go_next = 1'b1;
                        end else begin
                            step_next = {eff_step[5:2], 2'd0};
                        end
                    end
                end
                i2cm_pkg::SEC_RECV: begin
                    if (sub == 2'd0) begin
                        step_next = {eff_step[5:2], 2'd1};
                    end else begin
                        shift_next = {shift_next[6:0], item.sda_in};
                        bit_next   = eff_bit + 4'd1;
                        if (bit_next >= 4'd8) begin
                            go_next = 1'b1;
                        end else begin
                            step_next = {eff_step[5:2], 2'd0};
                        end
                    end
                end
                i2cm_pkg::SEC_ACK, i2cm_pkg::SEC_NOACK, i2cm_pkg::SEC_STOP: begin
                    if ((entry.sec == i2cm_pkg::SEC_ACK) && (sub == 2'd2) && item.sda_in) begin
                        nack_next = eff_nack | 3'(4'd1 << entry.arg);
                    end
                    if (sub < 2'd3) begin
                        step_next = {eff_step[5:2], sub + 2'd1};
                    end else begin
                        go_next = 1'b1;
                    end
                end
                default: begin
                    step_next = i2cm_pkg::IDLE_STEP;
                    finished  = 1'b1;
                end
            endcase
        end

        // advance to the next section of the plan
        nxt       = {1'b0, eff_step[5:2]} + 5'd1;
        nxt_entry = i2cm_pkg::plan_lookup(eff_kind, nxt[3:0]);
        if (go_next) begin
            if (nxt[4] || (nxt_entry.sec == i2cm_pkg::SEC_END)) begin
                step_next = i2cm_pkg::IDLE_STEP;
                finished  = 1'b1;
            end else begin
                step_next = {nxt[3:0], 2'd0};
                bit_next  = '0;
                if (nxt_entry.sec == i2cm_pkg::SEC_SEND) begin
                    case (nxt_entry.arg)
                        i2cm_pkg::SRC_DEVICE:   shift_next = eff_dev;
                        i2cm_pkg::SRC_REGISTER: shift_next = eff_regaddr;
                        i2cm_pkg::SRC_DATA:     shift_next = eff_wdata;
                        default:                shift_next = eff_dev + 8'd1;
                    endcase
                end
            end
        end

        // idle without a request: the lines keep their last levels
        result.scl_release   = active ? scl_next : scl_reg;
        result.sda_release   = active ? sda_next : sda_reg;
        result.busy_res      = active;
        result.done_res      = active && finished;
        result.write_aborted = active && aborted;
        result.start_fault   = active && finished && fault_next;
        result.nack_flags    = (active && finished) ? nack_next : 3'd0;
        result.read_data     = (active && finished && (eff_kind == i2cm_pkg::KIND_READ)) ?
                               shift_next : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= i2cm_pkg::IDLE_STEP;
            timer_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            kind_reg    <= 1'b0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            wdata_reg   <= '0;
            nack_reg    <= '0;
            fault_reg   <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end else if (step_en && active) begin
            step_reg    <= step_next;
            timer_reg   <= timer_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            kind_reg    <= eff_kind;
            dev_reg     <= eff_dev;
            regaddr_reg <= eff_regaddr;
            wdata_reg   <= eff_wdata;
            nack_reg    <= nack_next;
            fault_reg   <= fault_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

endmodule

/* design/i2c_master_register_access.sv */
// i2c_master_register_access: top level with stream ports, input register,
// result register and the phase_ticks configuration register.
// Depends on i2cm_pkg and i2cm_seq.
//
// Open-drain I2C master for single register writes and reads. Every input
// transfer is one tick of the bus timer: it carries a request (taken only
// while the block is idle) and the sampled SDA level, and every input
// transfer yields exactly one result transfer with the SCL/SDA drive levels,
// busy, and on the last tick of a transaction the done pulse with its abort,
// start-fault, no-acknowledge and read-byte fields. Each quarter-bit step
// lasts phase_ticks ticks (0 acts as 1). A write runs start, device byte,
// register byte, data byte, stop and aborts without a stop when the start
// check sees a busy or stuck SDA; a read runs start, device byte, register
// byte, repeated start, device byte plus one, one byte in, no-ack, stop.
// Throughput is one transfer per clock with no gaps while the sink takes
// results; each input transfer passes the input register and the result
// register on its way out. Write phase_ticks only while the block is idle.
module i2c_master_register_access #(
    parameter int PHASE_TIMER_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,      // phase_ticks

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] request_valid, [8:1] device_address, [16:9] register_address,
    // [24:17] write_data, [25] sda_in, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,     // [0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [4] write_aborted, [5] start_fault, [8:6] nack_flags,
    // [16:9] read_data, [23:17] zero
    output logic [23:0] m_axis_tdata
);

    logic [i2cm_pkg::PHASE_TICKS_W-1:0] phase_ticks_reg;
    logic                               in_valid_reg;
    i2cm_pkg::in_item_t                 in_item_reg;
    logic                               out_valid_reg;
    i2cm_pkg::result_t                  out_item_reg;
    i2cm_pkg::result_t                  step_result;
    logic                               advance;

    // advance the sequencer when an item waits and the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (cfg_wr_en) begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    // input register: hold the transfer until the sequencer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.request_valid    <= s_axis_tdata[0];
            in_item_reg.kind             <= s_axis_tuser;
            in_item_reg.device_address   <= s_axis_tdata[8:1];
            in_item_reg.register_address <= s_axis_tdata[16:9];
            in_item_reg.write_data       <= s_axis_tdata[24:17];
            in_item_reg.sda_in           <= s_axis_tdata[25];
        end
    end

    i2cm_seq #(
        .TIMER_W (PHASE_TIMER_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .phase_ticks (phase_ticks_reg),
        .step_en     (advance),
        .item        (in_item_reg),
        .result      (step_result)
    );

    // result register: keep the transfer until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_item_reg.read_data,
                            out_item_reg.nack_flags,
                            out_item_reg.start_fault,
                            out_item_reg.write_aborted,
                            out_item_reg.done_res,
                            out_item_reg.busy_res,
                            out_item_reg.sda_release,
                            out_item_reg.scl_release};

endmodule
